### hw/rtl/sgi_pkg.sv
// Shared types, constants and saturating fixed-point helpers for segment_intersection.
// No dependencies; every RTL file of the block refers to it by scoped names.
`default_nettype none

package sgi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIV_STEPS   = COORD_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0]        umag_t;
    typedef logic [DIV_STEPS-1:0]          dq_t;
    typedef logic [PROD_WIDTH-1:0]         prod_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam prod_t  MAG_POS_LIM = {{(PROD_WIDTH-COORD_WIDTH+1){1'b0}},
                                      {(COORD_WIDTH-1){1'b1}}};
    localparam prod_t  MAG_NEG_LIM = {{(PROD_WIDTH-COORD_WIDTH){1'b0}}, 1'b1,
                                      {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        coord_t ax0;
        coord_t ay0;
        coord_t ax1;
        coord_t ay1;
        coord_t bx0;
        coord_t by0;
        coord_t bx1;
        coord_t by1;
        logic   horiz;
        logic   miss;
        coord_t dbx;
        coord_t dby;
        coord_t fx;
        coord_t fy;
        coord_t ex;
        coord_t ey;
        coord_t q;
    } ctx_t;

    typedef struct packed {
        logic  neg;
        umag_t rem;
        dq_t   dq;
        umag_t den;
        ctx_t  ctx;
    } div_stage_t;

    function automatic coord_t sat_wide(input logic [COORD_WIDTH:0] s);
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return coord_t'(s[COORD_WIDTH-1:0]);
    endfunction

    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    function automatic coord_t sat_sub(input coord_t a, input coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    function automatic umag_t abs_mag(input coord_t a);
        return a[COORD_WIDTH-1] ? (umag_t'(0) - umag_t'(a)) : umag_t'(a);
    endfunction

    function automatic coord_t from_mag(input logic neg, input prod_t m);
        if (neg) begin
            if (m > MAG_NEG_LIM) begin
                return COORD_MIN;
            end
            return coord_t'(umag_t'(0) - m[COORD_WIDTH-1:0]);
        end
        if (m > MAG_POS_LIM) begin
            return COORD_MAX;
        end
        return coord_t'(m[COORD_WIDTH-1:0]);
    endfunction

    function automatic logic in_range(input coord_t v, input coord_t e0, input coord_t e1);
        return ((v >= e0) && (v <= e1)) || ((v <= e0) && (v >= e1));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/segment_intersection.sv
// Top level of segment_intersection: entry stage, two dividers, two multiplier pairs, hit test.
// Depends on sgi_pkg, sgi_div and sgi_mul.
//
//   channel  | handshake          | payload
//   s_       | s_valid / s_ready  | s_seg_a_{x0,y0,x1,y1}, s_seg_b_{x0,y0,x1,y1}
//   m_       | m_valid / m_ready  | m_hit, m_cross_x, m_cross_y
//
// One request per cycle while the pipeline is not stalled by m_ready.
// The two chains of DIV_STEPS division cells set the latency.
// Reset clears only valid bits; the datapath registers are not reset.
// A result waiting on m_ready stalls the pipeline only when the last stage holds a request.
`default_nettype none

module segment_intersection (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire sgi_pkg::coord_t s_seg_a_x0,
    input  wire sgi_pkg::coord_t s_seg_a_y0,
    input  wire sgi_pkg::coord_t s_seg_a_x1,
    input  wire sgi_pkg::coord_t s_seg_a_y1,
    input  wire sgi_pkg::coord_t s_seg_b_x0,
    input  wire sgi_pkg::coord_t s_seg_b_y0,
    input  wire sgi_pkg::coord_t s_seg_b_x1,
    input  wire sgi_pkg::coord_t s_seg_b_y1,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_hit,
    output sgi_pkg::coord_t      m_cross_x,
    output sgi_pkg::coord_t      m_cross_y
);

    logic            adv;
    logic            out_load;
    logic            s0_valid_reg;
    sgi_pkg::ctx_t   s0_ctx_reg, s0_ctx_next;
    sgi_pkg::coord_t s0_qnum_reg, s0_qden_reg;

    logic            d1_valid;
    sgi_pkg::coord_t d1_quot;
    sgi_pkg::ctx_t   d1_ctx, d1_ctx_q;

    logic            m1_valid;
    sgi_pkg::coord_t m1_r0, m1_r1;
    sgi_pkg::ctx_t   m1_ctx;

    logic            s1_valid_reg;
    sgi_pkg::ctx_t   s1_ctx_reg, s1_ctx_next;
    sgi_pkg::coord_t s1_num_reg, s1_num_next, s1_den_reg, s1_den_next;
    sgi_pkg::coord_t sn, fn;

    logic            d2_valid;
    sgi_pkg::coord_t d2_quot;
    sgi_pkg::ctx_t   d2_ctx;

    logic            m2_valid;
    sgi_pkg::coord_t m2_r0, m2_r1;
    sgi_pkg::ctx_t   m2_ctx;

    logic            s2_valid_reg;
    sgi_pkg::ctx_t   s2_ctx_reg;
    sgi_pkg::coord_t s2_px_reg, s2_py_reg;

    logic            hit_next;
    logic            m_valid_reg;
    logic            m_hit_reg;
    sgi_pkg::coord_t m_x_reg, m_y_reg;

    assign adv      = !(s2_valid_reg && m_valid_reg && !m_ready);
    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = adv;

    always_comb begin
        s0_ctx_next       = '0;
        s0_ctx_next.ax0   = s_seg_a_x0;
        s0_ctx_next.ay0   = s_seg_a_y0;
        s0_ctx_next.ax1   = s_seg_a_x1;
        s0_ctx_next.ay1   = s_seg_a_y1;
        s0_ctx_next.bx0   = s_seg_b_x0;
        s0_ctx_next.by0   = s_seg_b_y0;
        s0_ctx_next.bx1   = s_seg_b_x1;
        s0_ctx_next.by1   = s_seg_b_y1;
        s0_ctx_next.horiz = (s_seg_a_y0 == s_seg_a_y1);
        s0_ctx_next.dbx   = sgi_pkg::sat_sub(s_seg_b_x0, s_seg_b_x1);
        s0_ctx_next.dby   = sgi_pkg::sat_sub(s_seg_b_y0, s_seg_b_y1);
        s0_ctx_next.fx    = sgi_pkg::sat_sub(s_seg_b_x0, s_seg_a_x0);
        s0_ctx_next.fy    = sgi_pkg::sat_sub(s_seg_b_y0, s_seg_a_y0);
        s0_ctx_next.ex    = sgi_pkg::sat_sub(s_seg_b_x1, s_seg_b_x0);
        s0_ctx_next.ey    = sgi_pkg::sat_sub(s_seg_b_y1, s_seg_b_y0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_valid;
            s1_valid_reg <= m1_valid;
            s2_valid_reg <= m2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_ctx_reg  <= s0_ctx_next;
            s0_qnum_reg <= sgi_pkg::sat_sub(s_seg_a_x1, s_seg_a_x0);
            s0_qden_reg <= sgi_pkg::sat_sub(s_seg_a_y0, s_seg_a_y1);
        end
    end

    sgi_div u_div_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s0_valid_reg),
        .num       (s0_qnum_reg),
        .den       (s0_qden_reg),
        .in_ctx    (s0_ctx_reg),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_ctx   (d1_ctx)
    );

    always_comb begin
        d1_ctx_q   = d1_ctx;
        d1_ctx_q.q = d1_quot;
    end

    sgi_mul u_mul_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d1_valid),
        .a0        (d1_ctx.dby),
        .b0        (d1_quot),
        .a1        (d1_ctx.fy),
        .b1        (d1_quot),
        .in_ctx    (d1_ctx_q),
        .out_valid (m1_valid),
        .out_r0    (m1_r0),
        .out_r1    (m1_r1),
        .out_ctx   (m1_ctx)
    );

    always_comb begin
        sn          = sgi_pkg::sat_add(m1_ctx.dbx, m1_r0);
        fn          = sgi_pkg::sat_add(m1_ctx.fx, m1_r1);
        s1_num_next = m1_ctx.horiz ? m1_ctx.fy : fn;
        s1_den_next = m1_ctx.horiz ? m1_ctx.dby : sn;
        s1_ctx_next = m1_ctx;
        s1_ctx_next.miss = (s1_den_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctx_reg <= s1_ctx_next;
            s1_num_reg <= s1_num_next;
            s1_den_reg <= s1_den_next;
        end
    end

    sgi_div u_div_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .num       (s1_num_reg),
        .den       (s1_den_reg),
        .in_ctx    (s1_ctx_reg),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_ctx   (d2_ctx)
    );

    sgi_mul u_mul_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d2_valid),
        .a0        (d2_ctx.ex),
        .b0        (d2_quot),
        .a1        (d2_ctx.ey),
        .b1        (d2_quot),
        .in_ctx    (d2_ctx),
        .out_valid (m2_valid),
        .out_r0    (m2_r0),
        .out_r1    (m2_r1),
        .out_ctx   (m2_ctx)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_ctx_reg <= m2_ctx;
            s2_px_reg  <= sgi_pkg::sat_add(m2_ctx.bx0, m2_r0);
            s2_py_reg  <= sgi_pkg::sat_add(m2_ctx.by0, m2_r1);
        end
    end

    always_comb begin
        hit_next = !s2_ctx_reg.miss
            && sgi_pkg::in_range(s2_px_reg, s2_ctx_reg.ax0, s2_ctx_reg.ax1)
            && sgi_pkg::in_range(s2_py_reg, s2_ctx_reg.ay0, s2_ctx_reg.ay1)
            && sgi_pkg::in_range(s2_px_reg, s2_ctx_reg.bx0, s2_ctx_reg.bx1)
            && sgi_pkg::in_range(s2_py_reg, s2_ctx_reg.by0, s2_ctx_reg.by1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_reg <= hit_next;
            m_x_reg   <= hit_next ? s2_px_reg : '0;
            m_y_reg   <= hit_next ? s2_py_reg : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_cross_x = m_x_reg;
    assign m_cross_y = m_y_reg;

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_cross_x == '0 && m_cross_y == '0))
        else $error("miss with nonzero point");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("stall with empty output register");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped under stall");

endmodule

`default_nettype wire

### hw/rtl/sgi_div_cell.sv
// One restoring-division step: shift in a dividend bit, trial subtract, emit a quotient bit.
// Depends on sgi_pkg.
`default_nettype none

module sgi_div_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sgi_pkg::div_stage_t in_stage,
    output logic                    out_valid,
    output sgi_pkg::div_stage_t     out_stage
);

    logic [sgi_pkg::COORD_WIDTH:0] trial;
    logic [sgi_pkg::COORD_WIDTH:0] diff;
    logic                          ge;
    sgi_pkg::div_stage_t           stage_next;
    sgi_pkg::div_stage_t           stage_reg;
    logic                          valid_reg;

    always_comb begin
        trial      = {in_stage.rem, in_stage.dq[sgi_pkg::DIV_STEPS-1]};
        diff       = trial - {1'b0, in_stage.den};
        ge         = (trial >= {1'b0, in_stage.den});
        stage_next = in_stage;
        stage_next.rem = ge ? diff[sgi_pkg::COORD_WIDTH-1:0] : trial[sgi_pkg::COORD_WIDTH-1:0];
        stage_next.dq  = {in_stage.dq[sgi_pkg::DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

### hw/rtl/sgi_div.sv
// Signed saturating fixed-point divider: operand stage, a chain of division cells, result stage.
// Depends on sgi_pkg and sgi_div_cell.
`default_nettype none

module sgi_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire sgi_pkg::coord_t num,
    input  wire sgi_pkg::coord_t den,
    input  wire sgi_pkg::ctx_t   in_ctx,
    output logic                out_valid,
    output sgi_pkg::coord_t     out_quot,
    output sgi_pkg::ctx_t       out_ctx
);

    sgi_pkg::div_stage_t chain_w [0:sgi_pkg::DIV_STEPS];
    logic                chain_v [0:sgi_pkg::DIV_STEPS];
    sgi_pkg::div_stage_t head_reg;
    sgi_pkg::div_stage_t head_next;
    logic                head_valid_reg;
    sgi_pkg::coord_t     quot_reg;
    sgi_pkg::ctx_t       ctx_reg;
    logic                valid_reg;

    always_comb begin
        head_next.neg = num[sgi_pkg::COORD_WIDTH-1] ^ den[sgi_pkg::COORD_WIDTH-1];
        head_next.rem = '0;
        head_next.dq  = {sgi_pkg::abs_mag(num), {sgi_pkg::FRAC_BITS{1'b0}}};
        head_next.den = sgi_pkg::abs_mag(den);
        head_next.ctx = in_ctx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else if (en) begin
            head_valid_reg <= in_valid;
            valid_reg      <= chain_v[sgi_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            head_reg <= head_next;
            quot_reg <= sgi_pkg::from_mag(chain_w[sgi_pkg::DIV_STEPS].neg,
                                          sgi_pkg::prod_t'(chain_w[sgi_pkg::DIV_STEPS].dq));
            ctx_reg  <= chain_w[sgi_pkg::DIV_STEPS].ctx;
        end
    end

    assign chain_w[0] = head_reg;
    assign chain_v[0] = head_valid_reg;

    for (genvar i = 0; i < sgi_pkg::DIV_STEPS; i++) begin : g_cell
        sgi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[i]),
            .in_stage  (chain_w[i]),
            .out_valid (chain_v[i+1]),
            .out_stage (chain_w[i+1])
        );
    end

    assign out_valid = valid_reg;
    assign out_quot  = quot_reg;
    assign out_ctx   = ctx_reg;

endmodule

`default_nettype wire

### hw/rtl/sgi_mul.sv
// Two parallel signed saturating fixed-point multipliers in three register stages.
// Depends on sgi_pkg.
`default_nettype none

module sgi_mul (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire sgi_pkg::coord_t a0,
    input  wire sgi_pkg::coord_t b0,
    input  wire sgi_pkg::coord_t a1,
    input  wire sgi_pkg::coord_t b1,
    input  wire sgi_pkg::ctx_t   in_ctx,
    output logic                out_valid,
    output sgi_pkg::coord_t     out_r0,
    output sgi_pkg::coord_t     out_r1,
    output sgi_pkg::ctx_t       out_ctx
);

    logic           v1_reg, v2_reg, v3_reg;
    logic           neg0_reg, neg1_reg, neg0_s2_reg, neg1_s2_reg;
    sgi_pkg::umag_t ma0_reg, mb0_reg, ma1_reg, mb1_reg;
    sgi_pkg::prod_t p0_reg, p1_reg;
    sgi_pkg::coord_t r0_reg, r1_reg;
    sgi_pkg::ctx_t  ctx1_reg, ctx2_reg, ctx3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg    <= a0[sgi_pkg::COORD_WIDTH-1] ^ b0[sgi_pkg::COORD_WIDTH-1];
            neg1_reg    <= a1[sgi_pkg::COORD_WIDTH-1] ^ b1[sgi_pkg::COORD_WIDTH-1];
            ma0_reg     <= sgi_pkg::abs_mag(a0);
            mb0_reg     <= sgi_pkg::abs_mag(b0);
            ma1_reg     <= sgi_pkg::abs_mag(a1);
            mb1_reg     <= sgi_pkg::abs_mag(b1);
            ctx1_reg    <= in_ctx;
            p0_reg      <= sgi_pkg::prod_t'(ma0_reg) * sgi_pkg::prod_t'(mb0_reg);
            p1_reg      <= sgi_pkg::prod_t'(ma1_reg) * sgi_pkg::prod_t'(mb1_reg);
            neg0_s2_reg <= neg0_reg;
            neg1_s2_reg <= neg1_reg;
            ctx2_reg    <= ctx1_reg;
            r0_reg      <= sgi_pkg::from_mag(neg0_s2_reg, p0_reg >> sgi_pkg::FRAC_BITS);
            r1_reg      <= sgi_pkg::from_mag(neg1_s2_reg, p1_reg >> sgi_pkg::FRAC_BITS);
            ctx3_reg    <= ctx2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_r0    = r0_reg;
    assign out_r1    = r1_reg;
    assign out_ctx   = ctx3_reg;

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for segment_intersection: directed and random segment pairs.
// Predicts each crossing result in-line and compares it with the m_ channel in order.
// Depends on sgi_pkg and the segment_intersection RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        sgi_pkg::coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct {
        logic            hit;
        sgi_pkg::coord_t x;
        sgi_pkg::coord_t y;
    } crossing_t;

    localparam longint CMAX = longint'(sgi_pkg::COORD_MAX);
    localparam longint CMIN = longint'(sgi_pkg::COORD_MIN);
    localparam int     STALL_LIMIT = 20000;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    sgi_pkg::coord_t s_seg_a_x0 = '0, s_seg_a_y0 = '0, s_seg_a_x1 = '0, s_seg_a_y1 = '0;
    sgi_pkg::coord_t s_seg_b_x0 = '0, s_seg_b_y0 = '0, s_seg_b_x1 = '0, s_seg_b_y1 = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic            m_hit;
    sgi_pkg::coord_t m_cross_x, m_cross_y;

    segment_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_seg_a_x0(s_seg_a_x0), .s_seg_a_y0(s_seg_a_y0),
        .s_seg_a_x1(s_seg_a_x1), .s_seg_a_y1(s_seg_a_y1),
        .s_seg_b_x0(s_seg_b_x0), .s_seg_b_y0(s_seg_b_y0),
        .s_seg_b_x1(s_seg_b_x1), .s_seg_b_y1(s_seg_b_y1),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_cross_x(m_cross_x), .m_cross_y(m_cross_y)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    function automatic longint clamp(input longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint signed_from_mag(input bit neg, input logic [127:0] m);
        if (neg) begin
            if (m > 128'(CMAX + 1)) return CMIN;
            return -longint'(m[63:0]);
        end
        if (m > 128'(CMAX)) return CMAX;
        return longint'(m[63:0]);
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = (128'(abs64(a)) * 128'(abs64(b))) >> sgi_pkg::FRAC_BITS;
        return signed_from_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint q_div(input longint num, input longint den);
        logic [127:0] quo;
        quo = (128'(abs64(num)) << sgi_pkg::FRAC_BITS) / 128'(abs64(den));
        return signed_from_mag((num < 0) != (den < 0), quo);
    endfunction

    function automatic bit between(input longint v, input longint e0, input longint e1);
        return (v >= e0 && v <= e1) || (v <= e0 && v >= e1);
    endfunction

    function automatic crossing_t predict_crossing(input seg_pair_t p);
        crossing_t r;
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint slope, sn, fn, n, d, px, py;
        ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
        bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
        r = '{1'b0, '0, '0};
        if (ay1 != ay0) begin
            slope = q_div(clamp(ax1 - ax0), clamp(ay0 - ay1));
            sn = clamp(clamp(bx0 - bx1) + q_mul(clamp(by0 - by1), slope));
            if (sn == 0) return r;
            fn = clamp(clamp(bx0 - ax0) + q_mul(clamp(by0 - ay0), slope));
            n = q_div(fn, sn);
        end else begin
            d = clamp(by0 - by1);
            if (d == 0) return r;
            n = q_div(clamp(by0 - ay0), d);
        end
        px = clamp(bx0 + q_mul(clamp(bx1 - bx0), n));
        py = clamp(by0 + q_mul(clamp(by1 - by0), n));
        if (between(px, ax0, ax1) && between(py, ay0, ay1) &&
            between(px, bx0, bx1) && between(py, by0, by1)) begin
            r.hit = 1'b1;
            r.x = sgi_pkg::coord_t'(px);
            r.y = sgi_pkg::coord_t'(py);
        end
        return r;
    endfunction

    function automatic sgi_pkg::coord_t rand_coord(input int mode);
        case (mode)
            0: return sgi_pkg::coord_t'($urandom);
            1: return sgi_pkg::coord_t'(int'($urandom_range(0, 40)) - 20)
                      <<< sgi_pkg::FRAC_BITS;
            2: return sgi_pkg::coord_t'(int'($urandom_range(0, 2000000)) - 1000000);
            default: return sgi_pkg::coord_t'(int'($urandom_range(0, 200)) - 100)
                            <<< (sgi_pkg::FRAC_BITS - 2);
        endcase
    endfunction

    task automatic queue_pair(input sgi_pkg::coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
        seg_pair_t p;
        p = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
        pending_pairs.push_back(p);
    endtask

    task automatic queue_crossing_pair();
        sgi_pkg::coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        int mode;
        mode = $urandom_range(1, 3);
        ax0 = rand_coord(mode); ay0 = rand_coord(mode);
        ax1 = rand_coord(mode); ay1 = rand_coord(mode);
        // pick B through a point on A so many pairs really cross
        bx0 = sgi_pkg::coord_t'((longint'(ax0) + longint'(ax1)) / 2 + rand_coord(mode));
        by0 = sgi_pkg::coord_t'((longint'(ay0) + longint'(ay1)) / 2 + rand_coord(mode));
        bx1 = sgi_pkg::coord_t'(longint'(ax0) + longint'(ax1) - longint'(bx0));
        by1 = sgi_pkg::coord_t'(longint'(ay0) + longint'(ay1) - longint'(by0));
        if ($urandom_range(0, 9) == 0) ay1 = ay0;
        queue_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    endtask

    task automatic queue_random_pair();
        int mode;
        mode = $urandom_range(0, 3);
        queue_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_crossings.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                seg_pair_t p;
                p = pending_pairs.pop_front();
                expected_crossings.push_back(predict_crossing(p));
                s_valid <= 1'b1;
                s_seg_a_x0 <= p.ax0; s_seg_a_y0 <= p.ay0;
                s_seg_a_x1 <= p.ax1; s_seg_a_y1 <= p.ay1;
                s_seg_b_x0 <= p.bx0; s_seg_b_y0 <= p.by0;
                s_seg_b_x1 <= p.bx1; s_seg_b_y1 <= p.by1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles = quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_crossings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result hit=%0b", m_hit);
                end else begin
                    crossing_t e;
                    e = expected_crossings.pop_front();
                    if (m_hit !== e.hit || m_cross_x !== e.x || m_cross_y !== e.y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                     e.hit, e.x, e.y, m_hit, m_cross_x, m_cross_y);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int idle_cfg[4][2];
        idle_cfg = '{'{0, 0}, '{56, 0}, '{0, 56}, '{8, 8}};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, horizontal A, zero divisors, bounds and parallel pairs
        queue_pair(sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN,
                   sgi_pkg::COORD_MIN, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MIN);
        queue_pair(sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN,
                   sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN, sgi_pkg::COORD_MIN);
        queue_pair(sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX,
                   sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX, sgi_pkg::COORD_MAX);
        queue_pair(-32'sh20000, 32'sh0, 32'sh20000, 32'sh0,
                   32'sh0, -32'sh20000, 32'sh0, 32'sh20000);
        queue_pair(-32'sh20000, 32'sh10000, 32'sh20000, 32'sh10000,
                   32'sh0, 32'sh10000, 32'sh10000, 32'sh10000);
        queue_pair(-32'sh20000, -32'sh20000, 32'sh20000, 32'sh20000,
                   -32'sh20000, 32'sh20000, 32'sh20000, -32'sh20000);
        queue_pair(32'sh0, 32'sh0, 32'sh10000, 32'sh10000,
                   32'sh10000, 32'sh0, 32'sh20000, 32'sh10000);
        queue_pair(32'sh0, 32'sh0, 32'sh10000, 32'sh10000,
                   32'sh10000, 32'sh10000, 32'sh20000, 32'sh0);
        queue_pair(32'sh0, 32'sh0, 32'sh0, 32'sh40000,
                   -32'sh10000, 32'sh20000, 32'sh10000, 32'sh20000);
        queue_pair(32'sh0, 32'sh0, 32'sh10000, 32'sh10000,
                   32'sh50000, 32'sh0, 32'sh60000, 32'sh10000);
        queue_pair(sgi_pkg::COORD_MIN, 32'sh0, sgi_pkg::COORD_MAX, 32'sh1,
                   32'sh0, sgi_pkg::COORD_MIN, 32'sh1, sgi_pkg::COORD_MAX);
        queue_pair(32'sh1, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh1, 32'sh1);
        queue_pair(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0,
                   32'h0, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_cfg[ph][0];
            recv_stall_pct = idle_cfg[ph][1];
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 3) != 0) queue_crossing_pair();
                else queue_random_pair();
            end
            wait_drained();
        end
        repeat (120) @(posedge aclk);
        if (mismatches == 0 && expected_crossings.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/sgi_pkg.sv
hw/rtl/sgi_div_cell.sv
hw/rtl/sgi_div.sv
hw/rtl/sgi_mul.sv
hw/rtl/segment_intersection.sv
verif/tb.sv
